/* hdl/fqp_pkg.sv */
// Package for the FIFO queue with indexed peek: field widths, action and
// status codes, the request and response transfer types and the command
// group that the controller hands to the datapath. Depends on nothing.
package fqp_pkg;

   // Default sizing of the ring store.
   localparam int CAPACITY_DEF  = 16;
   localparam int WORD_BITS_DEF = 32;

   // Fixed widths of the transfer fields.
   localparam int ACTION_W = 2;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_PEEK    = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [DATA_W-1:0]  data_in;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data_out;
      logic [DATA_W-1:0]  front_word;
      logic [DATA_W-1:0]  back_word;
      logic [OCC_W-1:0]   occupancy;
      logic               is_empty;
      status_type         status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // update pointers, write or read the ring
      logic finish;    // form the response into the output register
   } cmd_type;

endpackage

/* hdl/fqp_ctrl.sv */
// Controller of the FIFO queue with indexed peek: a one-hot sequencer that
// accepts a request, steps it through execution and the ring read, and owns
// both handshakes. Depends on fqp_pkg.
module fqp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fqp_pkg::cmd_type cmd
);
   import fqp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_READ = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can be loaded when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.finish  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The response stays valid until its transfer completes.
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/fqp_datapath.sv */
// Datapath of the FIFO queue with indexed peek: the ring memory, head, tail
// and count registers, cached front and back words and the response
// register. Driven by commands from fqp_ctrl; depends on fqp_pkg.
module fqp_datapath #(
   parameter int CAPACITY  = fqp_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = fqp_pkg::WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  fqp_pkg::cmd_type cmd,
   input  fqp_pkg::req_type req_item,
   output fqp_pkg::rsp_type rsp_item
);
   import fqp_pkg::*;

   localparam int SW    = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Ring memory, one write and one registered read port.
   logic [SW-1:0]    mem [CAPACITY];
   logic             wr_en;
   logic [SW-1:0]    wr_data;
   logic [PTR_W-1:0] rd_addr;
   logic [SW-1:0]    rd_data_ff;

   req_type          item_ff;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SW-1:0]    front_ff, front_in, back_ff, back_in;
   logic [SW-1:0]    dout_ff, dout_in;
   logic             from_mem_ff, from_mem_in;
   logic             upd_front_ff, upd_front_in;
   status_type       code_ff, code_in;
   rsp_type          rsp_ff;

   logic [PTR_W-1:0] head_nx, tail_nx, peek_addr;
   logic [POS_W-1:0] offset;
   logic [SUM_W-1:0] sum;
   logic             full, empty, pos_bad;
   logic [SW-1:0]    cur_front, cur_dout;

   // Latch the accepted request.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
   end

   // Ring arithmetic: pointer wrap and the peek address.
   assign head_nx = (head_ff == PTR_W'(CAPACITY - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_nx = (tail_ff == PTR_W'(CAPACITY - 1)) ? '0 : tail_ff + PTR_W'(1);
   assign offset  = item_ff.position - POS_W'(1);
   assign sum     = SUM_W'(head_ff) + SUM_W'(offset);
   assign peek_addr = (sum >= SUM_W'(CAPACITY)) ? PTR_W'(sum - SUM_W'(CAPACITY))
                                                : PTR_W'(sum);

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_bad = (item_ff.position == '0) ||
                    (CMP_W'(item_ff.position) > CMP_W'(count_ff));
   assign wr_data = item_ff.data_in[SW-1:0];

   // Execution of the action and the front update at the end of an item.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      dout_in      = dout_ff;
      from_mem_in  = from_mem_ff;
      upd_front_in = upd_front_ff;
      code_in      = code_ff;
      wr_en        = 1'b0;
      rd_addr      = head_ff;
      if (cmd.execute) begin
         dout_in      = '0;
         from_mem_in  = 1'b0;
         upd_front_in = 1'b0;
         code_in      = ST_OK;
         case (item_ff.action)
            ACT_ENQUEUE: begin
               if (full) begin
                  code_in = ST_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = tail_nx;
                  count_in = count_ff + CNT_W'(1);
                  back_in  = wr_data;
                  if (empty) begin
                     front_in = wr_data;
                  end
               end
            end
            ACT_DEQUEUE: begin
               if (empty) begin
                  code_in = ST_UNDERFLOW;
               end else begin
                  // The outgoing word is the cached front; fetch the next one.
                  dout_in      = front_ff;
                  head_in      = head_nx;
                  count_in     = count_ff - CNT_W'(1);
                  rd_addr      = head_nx;
                  upd_front_in = (count_ff != CNT_W'(1));
               end
            end
            ACT_PEEK: begin
               if (pos_bad) begin
                  code_in = ST_RANGE;
               end else begin
                  rd_addr     = peek_addr;
                  from_mem_in = 1'b1;
               end
            end
            ACT_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
               code_in = ST_OK;
            end
         endcase
      end
      if (cmd.finish && upd_front_ff) begin
         front_in = rd_data_ff;
      end
   end

   // Ring write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= wr_data;
      end
   end

   // Ring read port with registered data.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Cached words and per-item results.
   always_ff @(posedge clock) begin
      front_ff     <= front_in;
      back_ff      <= back_in;
      dout_ff      <= dout_in;
      from_mem_ff  <= from_mem_in;
      upd_front_ff <= upd_front_in;
      code_ff      <= code_in;
   end

   // Response register, loaded only when the output side can take it.
   assign cur_front = upd_front_ff ? rd_data_ff : front_ff;
   assign cur_dout  = from_mem_ff ? rd_data_ff : dout_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.data_out   <= DATA_W'(cur_dout);
         rsp_ff.front_word <= empty ? '0 : DATA_W'(cur_front);
         rsp_ff.back_word  <= empty ? '0 : DATA_W'(back_ff);
         rsp_ff.occupancy  <= OCC_W'(count_ff);
         rsp_ff.is_empty   <= empty;
         rsp_ff.status     <= code_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

/* hdl/fifo_queue_with_indexed_peek.sv */
// FIFO queue with indexed peek. Each request enqueues a word, dequeues the
// oldest word, reads the word at a 1-based position from the front, or clears
// the queue, and produces exactly one response carrying the word read, the
// front and back words, the occupancy, an empty flag and a status code.
// Requests that cannot be served (overflow, underflow, bad position) report
// their status and leave the queue untouched. Each request passes through three
// steps before the next is accepted: acceptance, execution with the ring access,
// and the wait for the ring memory's registered read data. A finished
// response waits in the output register while the next request is already
// being worked on; only a response that is still stalled when the following
// one is ready holds the queue back. Store contents are not cleared at reset.
// Top level: instantiates fqp_ctrl and fqp_datapath; depends on fqp_pkg.
module fifo_queue_with_indexed_peek #(
   parameter int CAPACITY  = fqp_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = fqp_pkg::WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fqp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fqp_pkg::rsp_type rsp_item
);
   import fqp_pkg::*;

   cmd_type cmd;

   // Sequencer and handshakes.
   fqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Ring store, pointers and response register.
   fqp_datapath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule
